// ===== sv/wrpm_pkg.sv =====
// ----------------------------------------------------------------------------
// wrpm_pkg
// Shared types and constants of the windowed RMS/peak level meter.
// ----------------------------------------------------------------------------
package wrpm_pkg;

  localparam int MaxWindow = 2048;
  localparam int SumW      = 42;   // sum of squares
  localparam int CntW      = 12;   // sample count and window length
  localparam int SmpW      = 16;   // PCM sample
  localparam int LvlW      = 16;   // level, 1/256 dB
  localparam int ExpW      = 6;    // log2 integer part
  localparam int FracW     = 16;   // log2 fraction bits
  localparam int ManW      = 31;   // normalised mantissa
  localparam int LW        = 24;   // log2 difference, signed Q.16
  localparam int ScW       = 28;   // scale factor, signed
  localparam int ProdW     = 52;   // product of log and scale
  localparam int RndW      = 20;   // rounded level before clamping

  localparam logic signed [ScW-1:0] ScaleRms  = 28'sd50504453;
  localparam logic signed [ScW-1:0] ScalePeak = 28'sd101008905;
  localparam logic signed [LW-1:0]  RmsOffset  = 24'sd1966080;  // 30 * 2^16
  localparam logic signed [LW-1:0]  PeakOffset = 24'sd983040;   // 15 * 2^16

  localparam logic CfgWindowLength = 1'b0;
  localparam logic CfgLevelFloor   = 1'b1;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_ABORT  = 2'd1,
    KIND_CLOSE  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_NORM,
    S_SQR,
    S_ACC,
    S_MUL,
    S_RND,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_SS,
    PH_CNT,
    PH_PK
  } phase_e;

  typedef struct packed {
    logic   acc_sample;
    logic   set_blank;
    logic   set_start;
    logic   log_load;
    phase_e log_src;
    logic   norm_step;
    logic   sqr_init;
    logic   sqr_step;
    logic   l_load;
    logic   l_sub;
    logic   l_peak;
    logic   mul_en;
    logic   mul_peak;
    logic   rnd_rms;
    logic   rnd_peak;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    logic norm_top;
    logic sqr_last;
    logic ss_zero;
    logic pk_zero;
    logic win_full;
    logic cnt_zero;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/windowed_rms_peak_level_meter.sv =====
// ----------------------------------------------------------------------------
// windowed_rms_peak_level_meter
// RMS and peak level meter over a sample window, levels in 1/256 dBFS.
// ----------------------------------------------------------------------------
// Samples and ignored items are taken one per cycle. A window close
// (full window or close item) runs the level maths on one shared log2 unit:
// per logarithm up to 41 one-bit normalising shifts plus 16 squaring steps,
// three logarithms (sum, count, peak) plus scaling and rounding; a close
// holds the input until its result is loaded. An abort or a close of an
// empty window skips the maths. The finished result sits in an output register
// and the next window is accepted while it waits to be taken; a further close
// waits for that register to drain.
module windowed_rms_peak_level_meter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic                            cfg_index_i,
  input  logic [wrpm_pkg::LvlW-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      kind_i,
  input  logic signed [wrpm_pkg::SmpW-1:0] sample_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [wrpm_pkg::LvlW-1:0] rms_level_o,
  output logic signed [wrpm_pkg::LvlW-1:0] peak_level_o,
  output logic                            level_valid_o,
  output logic [wrpm_pkg::CntW-1:0]       samples_used_o
);
  import wrpm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  wrpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wrpm_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .sample_i       (sample_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .rms_level_o    (rms_level_o),
    .peak_level_o   (peak_level_o),
    .level_valid_o  (level_valid_o),
    .samples_used_o (samples_used_o)
  );

endmodule

// ===== sv/wrpm_ctrl.sv =====
// ----------------------------------------------------------------------------
// wrpm_ctrl
// Sequencer: accepts items and steps the datapath through the level maths.
// ----------------------------------------------------------------------------
module wrpm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          kind_i,
  output logic                in_stall_o,
  input  wrpm_pkg::sts_t      sts_i,
  output wrpm_pkg::cmd_t      cmd_o
);
  import wrpm_pkg::*;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_SS;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (kind_i)
            KIND_SAMPLE: if (sts_i.win_full) state_d = S_START;
            KIND_ABORT:  state_d = S_OUT;
            KIND_CLOSE:  state_d = sts_i.cnt_zero ? S_OUT : S_START;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_START: begin
        if (!sts_i.ss_zero) begin
          phase_d = PH_SS;
          state_d = S_NORM;
        end else if (!sts_i.pk_zero) begin
          phase_d = PH_PK;
          state_d = S_NORM;
        end else begin
          state_d = S_OUT;
        end
      end
      S_NORM: if (sts_i.norm_top) state_d = S_SQR;
      S_SQR:  if (sts_i.sqr_last) state_d = S_ACC;
      S_ACC: begin
        if (phase_q == PH_SS) begin
          phase_d = PH_CNT;
          state_d = S_NORM;
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL: state_d = S_RND;
      S_RND: begin
        if (phase_q == PH_CNT && !sts_i.pk_zero) begin
          phase_d = PH_PK;
          state_d = S_NORM;
        end else begin
          state_d = S_OUT;
        end
      end
      S_OUT:   if (sts_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    cmd_o.log_src = PH_SS;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (kind_i)
            KIND_SAMPLE: cmd_o.acc_sample = 1'b1;
            KIND_ABORT:  cmd_o.set_blank  = 1'b1;
            KIND_CLOSE:  cmd_o.set_blank  = sts_i.cnt_zero;
            default:     cmd_o.set_blank  = 1'b0;
          endcase
        end
      end
      S_START: begin
        cmd_o.set_start = 1'b1;
        cmd_o.log_load  = !sts_i.ss_zero || !sts_i.pk_zero;
        cmd_o.log_src   = !sts_i.ss_zero ? PH_SS : PH_PK;
      end
      S_NORM: begin
        cmd_o.norm_step = !sts_i.norm_top;
        cmd_o.sqr_init  = sts_i.norm_top;
      end
      S_SQR: cmd_o.sqr_step = 1'b1;
      S_ACC: begin
        case (phase_q)
          PH_SS: begin
            cmd_o.l_load   = 1'b1;
            cmd_o.log_load = 1'b1;
            cmd_o.log_src  = PH_CNT;
          end
          PH_CNT:  cmd_o.l_sub  = 1'b1;
          PH_PK:   cmd_o.l_peak = 1'b1;
          default: cmd_o.l_sub  = 1'b0;
        endcase
      end
      S_MUL: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_peak = (phase_q == PH_PK);
      end
      S_RND: begin
        if (phase_q == PH_PK) begin
          cmd_o.rnd_peak = 1'b1;
        end else begin
          cmd_o.rnd_rms  = 1'b1;
          cmd_o.log_load = !sts_i.pk_zero;
          cmd_o.log_src  = PH_PK;
        end
      end
      S_OUT:   cmd_o.out_load = sts_i.out_free;
      default: cmd_o.out_load = 1'b0;
    endcase
  end

endmodule

// ===== sv/wrpm_dp.sv =====
// ----------------------------------------------------------------------------
// wrpm_dp
// Datapath: window accumulators, shared log2 unit, scaling, output register.
// ----------------------------------------------------------------------------
module wrpm_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_index_i,
  input  logic [wrpm_pkg::LvlW-1:0]       cfg_data_i,
  input  logic signed [wrpm_pkg::SmpW-1:0] sample_i,
  input  wrpm_pkg::cmd_t                  cmd_i,
  output wrpm_pkg::sts_t                  sts_o,
  input  logic                            out_stall_i,
  output logic                            out_valid_o,
  output logic signed [wrpm_pkg::LvlW-1:0] rms_level_o,
  output logic signed [wrpm_pkg::LvlW-1:0] peak_level_o,
  output logic                            level_valid_o,
  output logic [wrpm_pkg::CntW-1:0]       samples_used_o
);
  import wrpm_pkg::*;

  logic [CntW-1:0]        wl_q;
  logic signed [LvlW-1:0] floor_q;
  logic [SumW-1:0]        ss_q;
  logic [SmpW-1:0]        pk_q;
  logic [CntW-1:0]        cnt_q;
  logic [SumW-1:0]        x_q;
  logic [ExpW-1:0]        e_q;
  logic [ManW-1:0]        m_q;
  logic [FracW-1:0]       frac_q;
  logic [3:0]             it_q;
  logic signed [LW-1:0]   l_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [LvlW-1:0] rms_q, peak_q;
  logic                   lv_q;
  logic [CntW-1:0]        used_q;
  logic                   out_valid_q;

  logic [SmpW-1:0]        mag;
  logic [CntW-1:0]        eff;
  logic [CntW:0]          cnt_inc;
  logic [SumW-1:0]        log_src;
  logic [2*ManW-1:0]      sq;
  logic [ManW:0]          sq_top;
  logic signed [LW-1:0]   logr;
  logic signed [ScW-1:0]  scale;
  logic signed [ProdW-1:0] rq;
  logic signed [RndW-1:0] rw;
  logic signed [LvlW-1:0] lvl;

  assign mag     = sample_i[SmpW-1] ? SmpW'(-sample_i) : sample_i;
  assign eff     = (wl_q == '0) ? CntW'(1) :
                   (wl_q > CntW'(MaxWindow)) ? CntW'(MaxWindow) : wl_q;
  assign cnt_inc = {1'b0, cnt_q} + (CntW+1)'(1);

  always_comb begin
    case (cmd_i.log_src)
      PH_SS:   log_src = ss_q;
      PH_CNT:  log_src = SumW'(cnt_q);
      PH_PK:   log_src = SumW'(pk_q);
      default: log_src = ss_q;
    endcase
  end

  assign sq     = m_q * m_q;
  assign sq_top = sq[2*ManW-1:ManW-1];     // (m*m) >> 30
  assign logr   = $signed(LW'({e_q, frac_q}));
  assign scale  = cmd_i.mul_peak ? ScalePeak : ScaleRms;

  // nearest, halves upward
  assign rq = prod_q + (ProdW'(1) <<< 31);
  assign rw = rq[ProdW-1:32];

  always_comb begin
    if (rw < RndW'(floor_q)) begin
      lvl = floor_q;
    end else if (rw > RndW'(0)) begin
      lvl = '0;
    end else begin
      lvl = rw[LvlW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q        <= CntW'(1600);
      floor_q     <= -16'sd20480;
      ss_q        <= '0;
      pk_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgWindowLength: wl_q    <= cfg_data_i[CntW-1:0];
          CfgLevelFloor:   floor_q <= cfg_data_i;
          default:         wl_q    <= wl_q;
        endcase
      end
      if (cmd_i.acc_sample) begin
        if (mag > pk_q) pk_q <= mag;
        ss_q  <= ss_q + SumW'(mag * mag);
        cnt_q <= cnt_inc[CntW-1:0];
      end
      if (cmd_i.out_load) begin
        ss_q  <= '0;
        pk_q  <= '0;
        cnt_q <= '0;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.log_load) begin
      x_q <= log_src;
      e_q <= ExpW'(SumW-1);
    end else if (cmd_i.norm_step) begin
      x_q <= x_q << 1;
      e_q <= e_q - ExpW'(1);
    end
    if (cmd_i.sqr_init) begin
      m_q    <= x_q[SumW-1 -: ManW];
      frac_q <= '0;
      it_q   <= '0;
    end else if (cmd_i.sqr_step) begin
      it_q   <= it_q + 4'd1;
      frac_q <= {frac_q[FracW-2:0], sq_top[ManW]};
      m_q    <= sq_top[ManW] ? sq_top[ManW:1] : sq_top[ManW-1:0];
    end
    if (cmd_i.l_load) begin
      l_q <= logr;
    end else if (cmd_i.l_sub) begin
      l_q <= l_q - logr - RmsOffset;
    end else if (cmd_i.l_peak) begin
      l_q <= logr - PeakOffset;
    end
    if (cmd_i.mul_en) begin
      prod_q <= ProdW'(l_q) * ProdW'(scale);
    end
    if (cmd_i.set_blank) begin
      rms_q  <= floor_q;
      peak_q <= floor_q;
      lv_q   <= 1'b0;
      used_q <= '0;
    end else if (cmd_i.set_start) begin
      rms_q  <= floor_q;
      peak_q <= floor_q;
      lv_q   <= 1'b1;
      used_q <= cnt_q;
    end
    if (cmd_i.rnd_rms)  rms_q  <= lvl;
    if (cmd_i.rnd_peak) peak_q <= lvl;
    if (cmd_i.out_load) begin
      rms_level_o    <= rms_q;
      peak_level_o   <= peak_q;
      level_valid_o  <= lv_q;
      samples_used_o <= used_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.norm_top  = x_q[SumW-1];
  assign sts_o.sqr_last  = (it_q == 4'd15);
  assign sts_o.ss_zero   = (ss_q == '0);
  assign sts_o.pk_zero   = (pk_q == '0);
  assign sts_o.win_full  = (cnt_inc >= {1'b0, eff});
  assign sts_o.cnt_zero  = (cnt_q == '0);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

// ===== sim/tb_windowed_rms_peak_level_meter.sv =====
// ----------------------------------------------------------------------------
// tb_windowed_rms_peak_level_meter
// Self-checking bench for the windowed RMS/peak level meter: directed tests of
// extremes, aborts, closes, window resizing and floor settings, then random
// windows under random idling and back-pressure. Every level is predicted
// bit-exactly in the bench and compared field by field.
// ----------------------------------------------------------------------------
module tb_windowed_rms_peak_level_meter;
  import wrpm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 600000;
  localparam int SettleCycles = 220;

  typedef struct {
    logic signed [LvlW-1:0] rms;
    logic signed [LvlW-1:0] peak;
    logic                   measured;
    logic [CntW-1:0]        used;
  } levels_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = 1'b0;
  logic [LvlW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] kind_i = KIND_SAMPLE;
  logic signed [SmpW-1:0] sample_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [LvlW-1:0] rms_level_o;
  logic signed [LvlW-1:0] peak_level_o;
  logic level_valid_o;
  logic [CntW-1:0] samples_used_o;

  windowed_rms_peak_level_meter DUT (.*);

  // bench copy of the meter state
  logic [CntW-1:0]          win_len_reg;
  logic signed [LvlW-1:0]   floor_reg;
  longint unsigned          sumsq_acc;
  int unsigned              peak_acc;
  int unsigned              count_acc;

  levels_t pending_levels[$];
  int      error_count = 0;
  int      cycle_count = 0;
  bit      calm = 1'b0;
  bit      hold_request = 1'b0;
  int      hold_left = 0;

  initial forever #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: random stalls, or a long counted hold-off on request
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (calm) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < 35);
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, expected %0d (cycle %0d)", what, got, want,
             cycle_count);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    levels_t exp_l;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_levels.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        exp_l = pending_levels.pop_front();
        if (rms_level_o !== exp_l.rms) report_mismatch("rms_level", rms_level_o, exp_l.rms);
        if (peak_level_o !== exp_l.peak)
          report_mismatch("peak_level", peak_level_o, exp_l.peak);
        if (level_valid_o !== exp_l.measured)
          report_mismatch("level_valid", level_valid_o, exp_l.measured);
        if (samples_used_o !== exp_l.used)
          report_mismatch("samples_used", samples_used_o, exp_l.used);
      end
    end
  end

  // log2 in Q.16 by repeated squaring of the normalised mantissa
  function automatic longint log2_q16(input longint unsigned x);
    int msb;
    longint unsigned m;
    longint frac;
    msb = 63;
    frac = 0;
    if (x == 0) return 0;
    while (x[msb] == 1'b0) msb--;
    m = (msb <= 30) ? (x << (30 - msb)) : (x >> (msb - 30));
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 64'h8000_0000) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return longint'(msb) * 65536 + frac;
  endfunction

  function automatic logic signed [LvlW-1:0] db_level(input longint l, input longint scale);
    longint q;
    q = (l * scale + 64'sh8000_0000) >>> 32;  // nearest, halves upward
    if (q < longint'(floor_reg)) q = floor_reg;
    else if (q > 0) q = 0;
    return q[LvlW-1:0];
  endfunction

  function automatic levels_t floor_levels();
    levels_t r;
    r.rms = floor_reg;
    r.peak = floor_reg;
    r.measured = 1'b0;
    r.used = '0;
    return r;
  endfunction

  function automatic levels_t close_window();
    levels_t r;
    r = floor_levels();
    r.measured = 1'b1;
    r.used = count_acc[CntW-1:0];
    if (sumsq_acc != 0)
      r.rms = db_level(log2_q16(sumsq_acc) - log2_q16(count_acc) - 30 * 65536,
                       longint'(ScaleRms));
    if (peak_acc != 0)
      r.peak = db_level(log2_q16(peak_acc) - 15 * 65536, longint'(ScalePeak));
    sumsq_acc = 0;
    peak_acc = 0;
    count_acc = 0;
    return r;
  endfunction

  // update the bench state for one accepted item, queue any result
  function automatic void predict_item(input logic [1:0] kind, input logic signed [SmpW-1:0] smp);
    int unsigned mag;
    int unsigned eff;
    case (kind)
      KIND_SAMPLE: begin
        mag = (smp < 0) ? -int'(smp) : int'(smp);
        eff = (win_len_reg == 0) ? 1 : (win_len_reg > MaxWindow ? MaxWindow : win_len_reg);
        if (mag > peak_acc) peak_acc = mag;
        sumsq_acc += longint'(mag) * longint'(mag);
        count_acc++;
        if (count_acc >= eff) pending_levels.push_back(close_window());
      end
      KIND_ABORT: begin
        sumsq_acc = 0;
        peak_acc = 0;
        count_acc = 0;
        pending_levels.push_back(floor_levels());
      end
      KIND_CLOSE: begin
        if (count_acc == 0) pending_levels.push_back(floor_levels());
        else pending_levels.push_back(close_window());
      end
      default: ;  // unused kind is ignored
    endcase
  endfunction

  // all tasks below start and end just after a rising edge
  task automatic send_item(input logic [1:0] kind, input logic signed [SmpW-1:0] smp);
    while (!calm && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    sample_i <= smp;
    do @(posedge clk_i); while (in_stall_o);
    predict_item(kind, smp);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [LvlW-1:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgWindowLength) win_len_reg = val[CntW-1:0];
    else floor_reg = val;
  endtask

  function automatic logic signed [SmpW-1:0] rand_sample();
    case ($urandom_range(5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return SmpW'(int'($urandom_range(511)) - 256);
      3: return 16'sd0;
      default: return SmpW'($urandom());
    endcase
  endfunction

  task automatic test_default_window();
    send_item(KIND_SAMPLE, 16'sd1000);
    send_item(KIND_SAMPLE, -16'sd1000);
    send_item(KIND_CLOSE, 16'sd0);
  endtask

  task automatic test_extremes();
    write_reg(CfgWindowLength, 16'd4);
    send_item(KIND_SAMPLE, 16'sh8000);
    send_item(KIND_SAMPLE, 16'sh7FFF);
    send_item(KIND_SAMPLE, -16'sd1);
    send_item(KIND_SAMPLE, 16'sd0);
    repeat (4) send_item(KIND_SAMPLE, 16'sd0);  // silent window
    repeat (4) send_item(KIND_SAMPLE, 16'sd1);  // quietest non-zero
  endtask

  task automatic test_abort_close();
    send_item(KIND_CLOSE, 16'sd0);              // close on empty window
    send_item(KIND_SAMPLE, 16'sd300);
    send_item(KIND_ABORT, 16'sd0);              // partial window dropped
    send_item(KIND_ABORT, 16'sd0);
    send_item(KIND_SAMPLE, -16'sd12345);
    send_item(KIND_CLOSE, 16'sd0);
    send_item(2'd3, 16'sh5A5A);                 // ignored
    send_item(2'd3, -16'sd1);
    send_item(KIND_SAMPLE, 16'sd7);
    send_item(KIND_CLOSE, 16'sd0);
  endtask

  task automatic test_window_resize();
    write_reg(CfgWindowLength, 16'd10);
    repeat (5) send_item(KIND_SAMPLE, rand_sample());
    write_reg(CfgWindowLength, 16'd2);          // below current count
    send_item(KIND_SAMPLE, rand_sample());
    write_reg(CfgWindowLength, 16'd0);          // length zero acts as one
    send_item(KIND_SAMPLE, -16'sd20000);
    write_reg(CfgWindowLength, 16'h0FFF);       // above the maximum
    repeat (4) send_item(KIND_SAMPLE, 16'sh8000);
    send_item(KIND_CLOSE, 16'sd0);
  endtask

  task automatic test_floor_settings();
    write_reg(CfgWindowLength, 16'd3);
    write_reg(CfgLevelFloor, 16'h8800);         // -120 dB
    repeat (3) send_item(KIND_SAMPLE, 16'sd1);
    send_item(KIND_ABORT, 16'sd0);
    write_reg(CfgLevelFloor, 16'h0000);         // everything clamps to 0
    repeat (3) send_item(KIND_SAMPLE, 16'sd100);
    write_reg(CfgLevelFloor, 16'h0064);         // floor above zero
    repeat (3) send_item(KIND_SAMPLE, 16'sh7FFF);
    send_item(KIND_CLOSE, 16'sd0);
    write_reg(CfgLevelFloor, 16'h8000);
    repeat (3) send_item(KIND_SAMPLE, 16'sd2);
  endtask

  task automatic test_backpressure();
    write_reg(CfgWindowLength, 16'd1);
    write_reg(CfgLevelFloor, -16'sd20480);
    calm = 1'b1;
    hold_request = 1'b1;
    repeat (12) send_item(KIND_SAMPLE, rand_sample());
    calm = 1'b0;
    drain();                                    // sender waits for every result
  endtask

  task automatic test_random();
    int left;
    int pick;
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(CfgWindowLength, LvlW'(($urandom_range(9) == 0) ? $urandom_range(4095)
                                                                : $urandom_range(1, 24)));
      case (phase % 3)
        0: write_reg(CfgLevelFloor, -16'sd30720);
        1: write_reg(CfgLevelFloor, LvlW'(-int'($urandom_range(30720))));
        default: write_reg(CfgLevelFloor, LvlW'($urandom()));
      endcase
      calm = (phase == 3);
      left = 64;
      while (left > 0) begin
        pick = $urandom_range(99);
        if (pick < 86) send_item(KIND_SAMPLE, rand_sample());
        else if (pick < 92) send_item(KIND_CLOSE, SmpW'($urandom()));
        else if (pick < 97) send_item(KIND_ABORT, SmpW'($urandom()));
        else begin
          send_item(2'd3, SmpW'($urandom()));
          left++;
        end
        left--;
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    win_len_reg = 1600;
    floor_reg = -16'sd20480;
    sumsq_acc = 0;
    peak_acc = 0;
    count_acc = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_window();
    test_extremes();
    test_abort_close();
    test_window_resize();
    test_floor_settings();
    test_backpressure();
    test_random();
    drain();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
